/* rtl/bdlp_pkg.sv */
// shared types, register codes and reset values for the button debouncer
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned DebW  = 16;
	localparam int unsigned AddrW = 4;
	localparam int unsigned DataW = 32;

	localparam logic             ActiveLowRst = 1'b1;
	localparam logic [DebW-1:0]  DebounceRst  = 16'd50;
	localparam logic [TimeW-1:0] LongPressRst = 32'd3000;
	localparam logic             EnabledRst   = 1'b0;

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_ACTIVE_LOW = 2'd0,
		REG_DEBOUNCE   = 2'd1,
		REG_LONG_PRESS = 2'd2,
		REG_ENABLED    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic             active_low;
		logic [DebW-1:0]  debounce_ms;
		logic [TimeW-1:0] long_press_ms;
		logic             enabled;
	} cfg_t;

	typedef struct packed {
		logic             raw_level;
		logic [TimeW-1:0] now_ms;
	} in_t;

	typedef struct packed {
		logic             press_event;
		logic             release_event;
		logic             long_event;
		logic             pressed_now;
		logic [TimeW-1:0] hold_ms;
	} out_t;

endpackage

`default_nettype wire

/* rtl/bdlp_regs.sv */
// apb configuration registers of the button debouncer
`timescale 1ns / 1ps
`default_nettype none

module bdlp_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bdlp_pkg::AddrW-1:0] paddr,
	input  logic [bdlp_pkg::DataW-1:0] pwdata,
	output logic [bdlp_pkg::DataW-1:0] prdata,
	output bdlp_pkg::cfg_t             cfg
);
	import bdlp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low    <= ActiveLowRst;
			cfg_q.debounce_ms   <= DebounceRst;
			cfg_q.long_press_ms <= LongPressRst;
			cfg_q.enabled       <= EnabledRst;
		end else if (wr_en) begin
			case (idx)
				REG_ACTIVE_LOW: cfg_q.active_low    <= pwdata[0];
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= pwdata[DebW-1:0];
				REG_LONG_PRESS: cfg_q.long_press_ms <= pwdata[TimeW-1:0];
				REG_ENABLED:    cfg_q.enabled       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ACTIVE_LOW: prdata = {{(DataW-1){1'b0}}, cfg_q.active_low};
			REG_DEBOUNCE:   prdata = {{(DataW-DebW){1'b0}}, cfg_q.debounce_ms};
			REG_LONG_PRESS: prdata = cfg_q.long_press_ms;
			REG_ENABLED:    prdata = {{(DataW-1){1'b0}}, cfg_q.enabled};
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/bdlp_core.sv */
// debounce state registers and the per-sample event logic
`timescale 1ns / 1ps
`default_nettype none

module bdlp_core (
	input  logic           clk,
	input  logic           arst_n,
	input  bdlp_pkg::cfg_t cfg,
	input  logic           step,
	input  bdlp_pkg::in_t  sample,
	output bdlp_pkg::out_t result
);
	import bdlp_pkg::*;

	logic             prev_raw_q;
	logic             stable_level_q;
	logic [TimeW-1:0] change_time_q;
	logic [TimeW-1:0] press_start_q;
	logic             long_done_q;

	logic             level;
	logic [TimeW-1:0] now;
	logic             pressed;
	logic [TimeW-1:0] change_time_d;
	logic [TimeW-1:0] press_start_d;
	logic             stable_level_d;
	logic             long_done_d;
	logic [TimeW-1:0] since_change;
	logic [TimeW-1:0] since_press;
	logic             settled;
	logic             press_ev;
	logic             release_ev;
	logic             long_ev;

	assign level   = sample.raw_level;
	assign now     = sample.now_ms;
	assign pressed = cfg.active_low ? ~level : level;

	always_comb begin
		change_time_d  = (level != prev_raw_q) ? now : change_time_q;
		since_change   = now - change_time_d;
		settled        = since_change > {{(TimeW-DebW){1'b0}}, cfg.debounce_ms};
		stable_level_d = stable_level_q;
		press_start_d  = press_start_q;
		long_done_d    = long_done_q;
		press_ev       = 1'b0;
		release_ev     = 1'b0;
		long_ev        = 1'b0;
		if (settled && (level != stable_level_q)) begin
			stable_level_d = level;
			if (pressed) begin
				press_start_d = now;
				long_done_d   = 1'b0;
				press_ev      = 1'b1;
			end else begin
				release_ev = 1'b1;
			end
		end
		since_press = now - press_start_d;
		if (settled && pressed && !long_done_d && (since_press >= cfg.long_press_ms)) begin
			long_done_d = 1'b1;
			long_ev     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q     <= 1'b1;
			stable_level_q <= 1'b1;
			change_time_q  <= '0;
			press_start_q  <= '0;
			long_done_q    <= 1'b0;
		end else if (step && cfg.enabled) begin
			prev_raw_q     <= level;
			stable_level_q <= stable_level_d;
			change_time_q  <= change_time_d;
			press_start_q  <= press_start_d;
			long_done_q    <= long_done_d;
		end
	end

	always_comb begin
		if (cfg.enabled) begin
			result.press_event   = press_ev;
			result.release_event = release_ev;
			result.long_event    = long_ev;
			result.pressed_now   = pressed;
			result.hold_ms       = pressed ? since_press : '0;
		end else begin
			result = '0;
		end
	end

endmodule

`default_nettype wire

/* rtl/button_debounce_long_press.sv */
// top level of the button debouncer with press, release and long-press flags
// a taken sample goes to the input register, its result to the output register
// throughput: one sample word per cycle unless the receiver stalls, set by
// the state update between the input register and the output register
// reset: arst_n clears handshake, debounce and configuration state at once
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_long_press (
	input  logic                       clk,
	input  logic                       arst_n,
	// apb configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bdlp_pkg::AddrW-1:0] paddr,
	input  logic [bdlp_pkg::DataW-1:0] pwdata,
	output logic [bdlp_pkg::DataW-1:0] prdata,
	output logic                       pready,
	// sample channel
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  bdlp_pkg::in_t              sample,
	// result channel
	output logic                       result_valid,
	input  logic                       result_ready,
	output bdlp_pkg::out_t             result
);
	import bdlp_pkg::*;

	cfg_t cfg;
	in_t  sample_s1;
	logic valid_s1;
	out_t result_d;
	out_t result_q;
	logic result_valid_q;
	logic advance;

	// no wait states on the configuration port
	assign pready = 1'b1;

	bdlp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// the word in s1 moves on when the output register is empty or being drained
	assign advance      = valid_s1 & (~result_valid_q | result_ready);
	assign sample_ready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	// debounce state advances once per word as it leaves s1, and only while enabled
	bdlp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.sample (sample_s1),
		.result (result_d)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

/* verif/button_debounce_long_press_tb.sv */
// self-checking testbench for the button debouncer with press, release and long-press flags
`timescale 1ns / 1ps

module button_debounce_long_press_tb;

	import bdlp_pkg::*;

	localparam int ClkPeriod   = 4;
	localparam int ResetCycles = 11;
	localparam int StallLimit  = 2000;  // cycles with no word moving on either channel
	localparam int HoldOffLen  = 400;   // long receiver stall, fills the block
	localparam int DrainCycles = 8;     // settling time after the final drain
	localparam int NumPhases   = 20;
	localparam int PhaseItems  = 55;
	localparam int IdlePct     = 35;

	// predicts the flags for every sample word and checks result words in order
	class button_tracker;
		cfg_t             cfg;
		logic             prev_raw;
		logic             stable_level;
		logic             long_done;
		logic [TimeW-1:0] change_time;
		logic [TimeW-1:0] press_start;
		out_t             expected_words[$];
		int               errors;

		function new();
			cfg = '{active_low: ActiveLowRst, debounce_ms: DebounceRst,
				long_press_ms: LongPressRst, enabled: EnabledRst};
			prev_raw     = 1'b1;
			stable_level = 1'b1;
			long_done    = 1'b0;
			change_time  = '0;
			press_start  = '0;
			errors       = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DataW-1:0] value);
			case (idx)
				REG_ACTIVE_LOW: cfg.active_low    = value[0];
				REG_DEBOUNCE:   cfg.debounce_ms   = value[DebW-1:0];
				REG_LONG_PRESS: cfg.long_press_ms = value[TimeW-1:0];
				REG_ENABLED:    cfg.enabled       = value[0];
				default:        ;
			endcase
		endfunction

		function void take_sample(in_t s);
			out_t             word;
			logic             pressed;
			logic [TimeW-1:0] since_change;
			logic [TimeW-1:0] since_press;
			word = '0;
			if (cfg.enabled) begin
				pressed = cfg.active_low ? !s.raw_level : s.raw_level;
				if (s.raw_level != prev_raw)
					change_time = s.now_ms;
				since_change = s.now_ms - change_time;
				if (since_change > TimeW'(cfg.debounce_ms)) begin
					if (s.raw_level != stable_level) begin
						stable_level = s.raw_level;
						if (pressed) begin
							press_start       = s.now_ms;
							long_done         = 1'b0;
							word.press_event  = 1'b1;
						end else begin
							word.release_event = 1'b1;
						end
					end
					since_press = s.now_ms - press_start;
					if (pressed && !long_done && since_press >= cfg.long_press_ms) begin
						long_done       = 1'b1;
						word.long_event = 1'b1;
					end
				end
				prev_raw         = s.raw_level;
				word.pressed_now = pressed;
				if (pressed)
					word.hold_ms = s.now_ms - press_start;
			end
			expected_words.push_back(word);
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (expected_words.size() == 0) begin
				$error("result word with no sample pending: %h", got);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			if (got.press_event !== want.press_event) begin
				$error("press_event: expected %0d, actual %0d", want.press_event, got.press_event);
				errors++;
			end
			if (got.release_event !== want.release_event) begin
				$error("release_event: expected %0d, actual %0d",
					want.release_event, got.release_event);
				errors++;
			end
			if (got.long_event !== want.long_event) begin
				$error("long_event: expected %0d, actual %0d", want.long_event, got.long_event);
				errors++;
			end
			if (got.pressed_now !== want.pressed_now) begin
				$error("pressed_now: expected %0d, actual %0d", want.pressed_now, got.pressed_now);
				errors++;
			end
			if (got.hold_ms !== want.hold_ms) begin
				$error("hold_ms: expected %0d, actual %0d", want.hold_ms, got.hold_ms);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;
	logic             sample_valid;
	logic             sample_ready;
	in_t              sample;
	logic             result_valid;
	logic             result_ready;
	out_t             result;

	button_tracker tracker = new();

	// shared knobs: idle chance for both sides, and a one-shot request for a long stall
	int idle_pct = IdlePct;
	bit hold_req = 1'b0;

	button_debounce_long_press i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	// monitor: note every sample word taken, check every result word taken
	always @(posedge clk) begin
		if (sample_valid && sample_ready)
			tracker.take_sample(sample);
		if (result_valid && result_ready)
			tracker.check_result(result);
	end

	// watchdog: give up when no word moves for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < StallLimit) begin
			@(posedge clk);
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// receiver: random back-pressure, plus one long hold-off counted here
	initial begin : receiver
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ready <= 1'b0;
				repeat (HoldOffLen) @(posedge clk);
			end
			result_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	function automatic in_t pin_sample(logic level, logic [TimeW-1:0] stamp);
		return '{raw_level: level, now_ms: stamp};
	endfunction

	// offer one sample word, with random gaps ahead of it, and wait until it is taken
	task automatic send_sample(in_t s);
		while ($urandom_range(99) < idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
	endtask

	// stop offering and wait until every predicted word has come back
	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_words.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle held until pready
	task automatic reg_write(reg_idx_t idx, logic [DataW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_reg(idx, value);
		@(posedge clk);
	endtask

	// registers only change with the block drained
	task automatic configure(logic al, logic [DebW-1:0] deb, logic [TimeW-1:0] lp, logic en);
		wait_drained();
		reg_write(REG_ACTIVE_LOW, DataW'(al));
		reg_write(REG_DEBOUNCE, DataW'(deb));
		reg_write(REG_LONG_PRESS, lp);
		reg_write(REG_ENABLED, DataW'(en));
	endtask

	initial begin : stimulus
		int unsigned      deb_i;
		int unsigned      lp_i;
		int unsigned      n_items;
		int unsigned      step_max;
		int unsigned      bounce_left;
		int unsigned      run_left;
		logic             al;
		logic             en;
		logic             want;
		logic             level;
		logic [TimeW-1:0] clock_ms;
		logic [TimeW-1:0] stamp;

		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		sample_valid <= 1'b0;
		sample       <= '0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pressed at reset: active-high wiring reads the idle-high reset level as held
		configure(1'b0, 16'd50, 32'd3000, 1'b1);
		send_sample(pin_sample(1'b1, 32'd10));
		send_sample(pin_sample(1'b1, 32'd5000));   // long flag with no press flag
		send_sample(pin_sample(1'b0, 32'd5100));
		send_sample(pin_sample(1'b0, 32'd5200));   // release

		// disabled: outputs all zero, state frozen
		configure(1'b1, 16'd50, 32'd3000, 1'b0);
		send_sample(pin_sample(1'b0, 32'hFFFF_FFFF));
		send_sample(pin_sample(1'b1, 32'h0000_0000));

		// flip polarity mid-press, then a full press with bounce edges at the limits
		configure(1'b1, 16'd50, 32'd3000, 1'b1);
		send_sample(pin_sample(1'b0, 32'd5300));
		send_sample(pin_sample(1'b1, 32'd5400));   // raw change, nothing accepted
		send_sample(pin_sample(1'b1, 32'd5451));   // release
		send_sample(pin_sample(1'b0, 32'd5500));
		send_sample(pin_sample(1'b0, 32'd5550));   // exactly the debounce time, not past it
		send_sample(pin_sample(1'b0, 32'd5551));   // press
		send_sample(pin_sample(1'b0, 32'd8550));   // one short of long press
		send_sample(pin_sample(1'b0, 32'd8551));   // long press
		send_sample(pin_sample(1'b0, 32'd9000));   // long flag only once

		// zero debounce and zero long-press time across the timestamp wrap
		configure(1'b1, 16'd0, 32'd0, 1'b1);
		send_sample(pin_sample(1'b1, 32'hFFFF_FFF0));
		send_sample(pin_sample(1'b1, 32'hFFFF_FFFE));
		send_sample(pin_sample(1'b0, 32'hFFFF_FFFF));
		send_sample(pin_sample(1'b0, 32'h0000_0000));  // press and long on the same word
		send_sample(pin_sample(1'b0, 32'h0000_0005));

		// largest debounce and long-press times
		configure(1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		send_sample(pin_sample(1'b1, 32'd10));
		send_sample(pin_sample(1'b1, 32'd65545));
		send_sample(pin_sample(1'b1, 32'd65546));
		send_sample(pin_sample(1'b1, 32'h8000_0000));
		send_sample(pin_sample(1'b0, 32'hFFFF_FFFF));

		// random phases: mostly bounce-then-hold episodes, some noise words
		clock_ms    = $urandom();
		want        = 1'b1;
		bounce_left = 0;
		run_left    = 0;
		for (int p = 0; p < NumPhases; p++) begin
			al    = 1'($urandom_range(0, 1));
			deb_i = ($urandom_range(99) < 15) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
			case ($urandom_range(0, 6))
				0:       lp_i = 0;
				1:       lp_i = $urandom();
				default: lp_i = $urandom_range(0, 300);
			endcase
			en      = 1'b1;
			n_items = PhaseItems;
			if (p == 1) begin
				al    = 1'b0;
				deb_i = 0;
				lp_i  = 0;
			end else if (p == 2) begin
				al    = 1'b1;
				deb_i = 65535;
				lp_i  = 32'hFFFF_FFFF;
			end else if (p == 7) begin
				en      = 1'b0;
				n_items = 10;
			end
			configure(al, DebW'(deb_i), lp_i, en);

			// one phase without any idling, one with the long receiver stall
			idle_pct = (p == 4) ? 0 : IdlePct;
			if (p == 9)
				hold_req = 1'b1;

			step_max = deb_i / 2 + ((lp_i > 400) ? 50 : lp_i / 8) + 2;
			if ($urandom_range(99) < 20)
				clock_ms = $urandom();

			for (int k = 0; k < n_items; k++) begin
				if ($urandom_range(99) < 10) begin
					// noise word anywhere in time
					level = 1'($urandom_range(0, 1));
					stamp = $urandom();
					if ($urandom_range(0, 1))
						clock_ms = stamp;
				end else begin
					if (run_left == 0) begin
						want        = !want;
						bounce_left = $urandom_range(0, 4);
						run_left    = $urandom_range(2, 12);
					end
					if (bounce_left != 0) begin
						level       = bounce_left[0] ? !want : want;
						bounce_left = bounce_left - 1;
						clock_ms    = clock_ms + $urandom_range(0, deb_i / 4 + 1);
					end else begin
						level    = want;
						run_left = run_left - 1;
						clock_ms = clock_ms + $urandom_range(0, step_max);
					end
					stamp = clock_ms;
				end
				send_sample(pin_sample(level, stamp));
			end
		end

		// all words offered: drain and let the pipeline settle
		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (tracker.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
